/* rtl/hss_pkg.sv */
// Package for the five-point heat stencil stream: word types, widths, register codes.
// Used by every module of the block; depends on nothing else.
package hss_pkg;

    // Field widths of the streamed words.
    localparam int SAMPLE_W   = 32;
    localparam int IDX_W      = 10;
    localparam int GRID_W     = 11;
    localparam int LAMBDA_W   = 16;
    localparam int Q_FRAC     = 16;

    // Internal arithmetic widths: difference sum, product, final sum.
    localparam int DIFF_W     = SAMPLE_W + 3;
    localparam int PROD_W     = DIFF_W + LAMBDA_W + 1;
    localparam int PSUM_W     = SAMPLE_W + 5;

    // One line store entry holds the older row and the previous row.
    localparam int LINE_W     = 2 * SAMPLE_W;

    // Grid limits and register reset values.
    localparam int MAX_GRID_DEF = 1024;
    localparam int MIN_GRID     = 3;
    localparam logic [GRID_W-1:0]   GRID_SIZE_RST = 11'd1024;
    localparam logic [LAMBDA_W-1:0] LAMBDA_RST    = 16'd16384;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_Q16 = 8'd1;

    // Input word: one grid sample in raster order.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_start;
    } in_word_t;

    // Output word: one updated interior cell.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] new_value;
        logic [IDX_W-1:0]           row_index;
        logic [IDX_W-1:0]           col_index;
        logic                       last;
    } out_word_t;

    // Position information of the cell evaluated for one sample.
    typedef struct packed {
        logic             emit;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic             last;
    } pos_t;

endpackage

/* rtl/hss_position.sv */
// Raster position tracking for the heat stencil stream.
// Depends on hss_pkg for widths and the position struct.
module hss_position #(
    parameter int MAX_GRID = hss_pkg::MAX_GRID_DEF,
    localparam int AW = $clog2(MAX_GRID)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        frame_start,
    input  logic [hss_pkg::GRID_W-1:0]  grid_size,
    output logic [AW-1:0]               col_addr,
    output hss_pkg::pos_t               pos
);

    localparam int NW = (AW + 1 > hss_pkg::GRID_W) ? AW + 1 : hss_pkg::GRID_W;

    logic [AW-1:0] row_reg;
    logic [AW-1:0] row_next;
    logic [AW-1:0] col_reg;
    logic [AW-1:0] col_next;
    logic [NW-1:0] size_ext;
    logic [NW-1:0] n_eff;
    logic [NW-1:0] row_cur;
    logic [NW-1:0] col_cur;
    logic [NW-1:0] row_inc;
    logic [NW-1:0] col_inc;
    logic [NW-1:0] row_m1;
    logic [NW-1:0] col_m1;
    logic          wrap;

    // Clamp the grid side, place the sample and work out the next position.
    always_comb
    begin
        size_ext = NW'(grid_size);
        if (size_ext < NW'(hss_pkg::MIN_GRID))
        begin
            n_eff = NW'(hss_pkg::MIN_GRID);
        end
        else if (size_ext > NW'(MAX_GRID))
        begin
            n_eff = NW'(MAX_GRID);
        end
        else
        begin
            n_eff = size_ext;
        end

        // A frame start or a position past the grid restarts at the origin.
        wrap = frame_start || (NW'(row_reg) >= n_eff) || (NW'(col_reg) >= n_eff);
        row_cur = wrap ? '0 : NW'(row_reg);
        col_cur = wrap ? '0 : NW'(col_reg);

        col_inc = col_cur + NW'(1);
        row_inc = row_cur;
        if (col_inc >= n_eff)
        begin
            col_inc = '0;
            row_inc = row_cur + NW'(1);
            if (row_inc >= n_eff)
            begin
                row_inc = '0;
            end
        end
        row_next = row_inc[AW-1:0];
        col_next = col_inc[AW-1:0];

        // The cell one row up and one column left is the one evaluated.
        row_m1 = row_cur - NW'(1);
        col_m1 = col_cur - NW'(1);
        pos.emit      = (row_cur >= NW'(2)) && (col_cur >= NW'(2));
        pos.row_index = row_m1[hss_pkg::IDX_W-1:0];
        pos.col_index = col_m1[hss_pkg::IDX_W-1:0];
        pos.last      = (row_cur == n_eff - NW'(1)) && (col_cur == n_eff - NW'(1));
        col_addr      = col_cur[AW-1:0];
    end

    // Position of the next sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (advance)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

/* rtl/hss_line_store.sv */
// Line store memory holding the two rows above the incoming sample, with a
// clearing pass after reset and write-to-read forwarding. Depends on hss_pkg.
module hss_line_store #(
    parameter int DEPTH = hss_pkg::MAX_GRID_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [hss_pkg::LINE_W-1:0]  wr_data,
    output logic [hss_pkg::LINE_W-1:0]  rd_data,
    output logic                        busy
);

    logic [hss_pkg::LINE_W-1:0] mem [DEPTH];
    logic [hss_pkg::LINE_W-1:0] mem_q_reg;
    logic [hss_pkg::LINE_W-1:0] fwd_data_reg;
    logic                       fwd_hit_reg;
    logic                       busy_reg;
    logic [AW-1:0]              clr_reg;
    logic                       port_we;
    logic [AW-1:0]              port_addr;
    logic [hss_pkg::LINE_W-1:0] port_data;

    // The clearing pass owns the write port until every entry is zero.
    always_comb
    begin
        port_we   = busy_reg || wr_en;
        port_addr = busy_reg ? clr_reg : wr_addr;
        port_data = busy_reg ? '0 : wr_data;
    end

    // Clearing pass sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            clr_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_reg == AW'(DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (port_we)
        begin
            mem[port_addr] <= port_data;
        end
    end

    // Memory read port with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // A write to the address being read in the same cycle is forwarded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : mem_q_reg;
    assign busy    = busy_reg;

endmodule

/* rtl/hss_update.sv */
// Update pipeline: lambda multiply, floor shift, add and saturate, output register.
// Depends on hss_pkg for widths, the position struct and the output word.
module hss_update (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [hss_pkg::LAMBDA_W-1:0]        lambda_q16,
    input  logic                                in_valid,
    output logic                                in_space,
    input  logic signed [hss_pkg::DIFF_W-1:0]   diff,
    input  logic signed [hss_pkg::SAMPLE_W-1:0] center,
    input  hss_pkg::pos_t                       pos,
    output logic                                out_valid,
    input  logic                                out_stall,
    output hss_pkg::out_word_t                  out_data
);

    localparam int QW = hss_pkg::PROD_W - hss_pkg::Q_FRAC;

    logic                                b_valid_reg;
    logic signed [hss_pkg::DIFF_W-1:0]   b_diff_reg;
    logic signed [hss_pkg::SAMPLE_W-1:0] b_ctr_reg;
    hss_pkg::pos_t                       b_pos_reg;
    logic                                c_valid_reg;
    logic signed [hss_pkg::PROD_W-1:0]   c_prod_reg;
    logic signed [hss_pkg::PROD_W-1:0]   c_prod_next;
    logic signed [hss_pkg::SAMPLE_W-1:0] c_ctr_reg;
    hss_pkg::pos_t                       c_pos_reg;
    logic                                o_valid_reg;
    hss_pkg::out_word_t                  o_data_reg;
    hss_pkg::out_word_t                  o_data_next;
    logic signed [hss_pkg::LAMBDA_W:0]   lam_s;
    logic signed [QW-1:0]                quot;
    logic signed [hss_pkg::PSUM_W-1:0]   total;
    logic                                o_free;
    logic                                c_move;
    logic                                c_space;
    logic                                b_move;

    // Each stage moves on when the one after it is empty or moving too.
    always_comb
    begin
        o_free   = !o_valid_reg || !out_stall;
        c_move   = c_valid_reg && o_free;
        c_space  = !c_valid_reg || c_move;
        b_move   = b_valid_reg && c_space;
        in_space = !b_valid_reg || b_move;
    end

    // Multiply stage: unsigned Q0.16 lambda times the signed difference.
    always_comb
    begin
        lam_s       = $signed({1'b0, lambda_q16});
        c_prod_next = hss_pkg::PROD_W'(lam_s) * hss_pkg::PROD_W'(b_diff_reg);
    end

    // Final stage: floor shift, add the center, clamp to 32 bits.
    always_comb
    begin
        quot  = c_prod_reg[hss_pkg::PROD_W-1:hss_pkg::Q_FRAC];
        total = hss_pkg::PSUM_W'(c_ctr_reg) + hss_pkg::PSUM_W'(quot);
        if (total[hss_pkg::PSUM_W-1:hss_pkg::SAMPLE_W-1] == '0
            || total[hss_pkg::PSUM_W-1:hss_pkg::SAMPLE_W-1] == '1)
        begin
            o_data_next.new_value = total[hss_pkg::SAMPLE_W-1:0];
        end
        else if (total[hss_pkg::PSUM_W-1])
        begin
            o_data_next.new_value = {1'b1, {(hss_pkg::SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            o_data_next.new_value = {1'b0, {(hss_pkg::SAMPLE_W-1){1'b1}}};
        end
        o_data_next.row_index = c_pos_reg.row_index;
        o_data_next.col_index = c_pos_reg.col_index;
        o_data_next.last      = c_pos_reg.last;
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_space)
            begin
                b_valid_reg <= in_valid;
            end
            if (c_space)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (o_free)
            begin
                o_valid_reg <= c_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (in_space && in_valid)
        begin
            b_diff_reg <= diff;
            b_ctr_reg  <= center;
            b_pos_reg  <= pos;
        end
        if (b_move)
        begin
            c_prod_reg <= c_prod_next;
            c_ctr_reg  <= b_ctr_reg;
            c_pos_reg  <= b_pos_reg;
        end
        if (c_move)
        begin
            o_data_reg <= o_data_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule

/* rtl/heat_stencil_5pt_stream.sv */
// Top level of the five-point heat stencil stream: configuration registers,
// sample stage, window registers. Depends on hss_pkg, hss_position,
// hss_line_store and hss_update.
//
// Usage: samples of an N by N grid enter in raster order on the input channel
// (in_valid/in_stall/in_data), with frame_start set on the first sample of a
// grid. For every sample that completes the neighborhood of an interior cell,
// one word with the new value, its row, its column and a last flag leaves on
// the output channel (out_valid/out_stall/out_data). Boundary cells give no word.
// Throughput is one sample per cycle unless in_stall holds the input; a word passes
// the sample register, then the difference, product and result registers, before
// it appears at the outputs. The grid side and lambda are written through the cfg
// port, which is always ready; the user must write them only while the block is
// idle, which the block does not enforce. After reset the line store clears its
// MAX_GRID entries, one entry per cycle, and in_stall stays high until the pass
// ends. When the receiver stalls, the result register holds its word, the pipeline
// stages behind it still fill, and in_stall rises only once every stage is occupied.
module heat_stencil_5pt_stream #(
    parameter int MAX_GRID = hss_pkg::MAX_GRID_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  hss_pkg::in_word_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output hss_pkg::out_word_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_GRID);

    logic [hss_pkg::GRID_W-1:0]          grid_size_reg;
    logic [hss_pkg::LAMBDA_W-1:0]        lambda_reg;
    logic                                accept;
    logic                                busy;
    logic [AW-1:0]                       col_addr;
    hss_pkg::pos_t                       pos;
    logic                                a_valid_reg;
    logic signed [hss_pkg::SAMPLE_W-1:0] a_sample_reg;
    logic [AW-1:0]                       a_addr_reg;
    hss_pkg::pos_t                       a_pos_reg;
    logic                                a_move;
    logic                                a_space;
    logic                                upd_space;
    logic [hss_pkg::LINE_W-1:0]          rd_data;
    logic signed [hss_pkg::SAMPLE_W-1:0] top;
    logic signed [hss_pkg::SAMPLE_W-1:0] mid;
    logic signed [hss_pkg::DIFF_W-1:0]   diff;
    logic signed [hss_pkg::SAMPLE_W-1:0] w_north_reg;
    logic signed [hss_pkg::SAMPLE_W-1:0] w_west_reg;
    logic signed [hss_pkg::SAMPLE_W-1:0] w_ctr_reg;
    logic signed [hss_pkg::SAMPLE_W-1:0] w_south_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= hss_pkg::GRID_SIZE_RST;
            lambda_reg    <= hss_pkg::LAMBDA_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hss_pkg::CFG_GRID_SIZE:  grid_size_reg <= cfg_data[hss_pkg::GRID_W-1:0];
                hss_pkg::CFG_LAMBDA_Q16: lambda_reg    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Handshake of the sample stage.
    always_comb
    begin
        a_move   = a_valid_reg && (!a_pos_reg.emit || upd_space);
        a_space  = !a_valid_reg || a_move;
        in_stall = busy || !a_space;
        accept   = in_valid && !in_stall;
    end

    hss_position #(
        .MAX_GRID   (MAX_GRID)
    ) u_position (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (accept),
        .frame_start(in_data.frame_start),
        .grid_size  (grid_size_reg),
        .col_addr   (col_addr),
        .pos        (pos)
    );

    // The store entry read for a sample is rewritten when that sample moves on:
    // the older row takes the previous row, the previous row takes the sample.
    hss_line_store #(
        .DEPTH      (MAX_GRID)
    ) u_line_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept),
        .rd_addr    (col_addr),
        .wr_en      (a_move),
        .wr_addr    (a_addr_reg),
        .wr_data    ({mid, a_sample_reg}),
        .rd_data    (rd_data),
        .busy       (busy)
    );

    // Sample stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_space)
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_sample_reg <= in_data.sample;
            a_addr_reg   <= col_addr;
            a_pos_reg    <= pos;
        end
    end

    // Neighbor difference: north + south + east + west - 4 * center.
    always_comb
    begin
        top  = $signed(rd_data[hss_pkg::LINE_W-1:hss_pkg::SAMPLE_W]);
        mid  = $signed(rd_data[hss_pkg::SAMPLE_W-1:0]);
        diff = hss_pkg::DIFF_W'(w_north_reg) + hss_pkg::DIFF_W'(w_south_reg)
             + hss_pkg::DIFF_W'(mid) + hss_pkg::DIFF_W'(w_west_reg)
             - (hss_pkg::DIFF_W'(w_ctr_reg) <<< 2);
    end

    // Window registers shift by one column for every sample that moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_north_reg <= '0;
            w_west_reg  <= '0;
            w_ctr_reg   <= '0;
            w_south_reg <= '0;
        end
        else if (a_move)
        begin
            w_north_reg <= top;
            w_west_reg  <= w_ctr_reg;
            w_ctr_reg   <= mid;
            w_south_reg <= a_sample_reg;
        end
    end

    hss_update u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .lambda_q16 (lambda_reg),
        .in_valid   (a_move && a_pos_reg.emit),
        .in_space   (upd_space),
        .diff       (diff),
        .center     (w_ctr_reg),
        .pos        (a_pos_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

/* rtl/hss_checker.sv */
// Port-level checks for the heat stencil stream, bound to the top level.
// Depends on hss_pkg for the word types.
module hss_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_stall,
    input  logic               out_valid,
    input  logic               out_stall,
    input  hss_pkg::out_word_t out_data
);

    // A stalled result word stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // The line store clearing pass blocks input right after reset.
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall)
        else $error("input accepted during line store clearing");

    // The final interior cell lies on the diagonal.
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> out_data.row_index == out_data.col_index)
        else $error("last word off the diagonal");

    // After the final cell of a grid no word can follow at once.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.last |=> !out_valid)
        else $error("word directly after the last cell of a grid");

endmodule

bind heat_stencil_5pt_stream hss_checker u_hss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

/* test/heat_stencil_5pt_stream_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the five-point heat stencil stream.
// Holds its own stencil predictor and a queue of expected cells; depends on hss_pkg
// and heat_stencil_5pt_stream only.
module heat_stencil_5pt_stream_tb;

    // Pipeline settle margin after the last expected word, in cycles.
    localparam int DRAIN_CYCLES = 8;
    // Register index that maps to nothing in the block.
    localparam logic [hss_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 8'd2;
    localparam logic signed [hss_pkg::SAMPLE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [hss_pkg::SAMPLE_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    // One row of the directed plan: optional register setup, the sample word,
    // and a typed-in value where the result is obvious.
    typedef struct {
        bit                                  set_cfg;
        logic [hss_pkg::GRID_W-1:0]          grid;
        logic [hss_pkg::LAMBDA_W-1:0]        lam;
        hss_pkg::in_word_t                   w;
        bit                                  typed;
        logic signed [hss_pkg::SAMPLE_W-1:0] typed_val;
    } plan_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    hss_pkg::in_word_t              in_data;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    hss_pkg::out_word_t             out_data;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [hss_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hss_pkg::CFG_DATA_W-1:0] cfg_data;

    // Predictor state: register copies, two line stores, window, position.
    logic [hss_pkg::GRID_W-1:0]          grid_reg;
    logic [hss_pkg::LAMBDA_W-1:0]        lambda_reg;
    logic signed [hss_pkg::SAMPLE_W-1:0] older_line  [hss_pkg::MAX_GRID_DEF];
    logic signed [hss_pkg::SAMPLE_W-1:0] recent_line [hss_pkg::MAX_GRID_DEF];
    logic signed [hss_pkg::SAMPLE_W-1:0] win_top, win_west, win_mid, win_last;
    int unsigned                         pos_row, pos_col;

    hss_pkg::out_word_t pending_cells [$];
    plan_row_t          plan [$];
    hss_pkg::out_word_t want;
    int                 err_cnt = 0;
    int                 send_gap = 0;
    int                 recv_stall = 0;

    heat_stencil_5pt_stream u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #6_000_000;
        $display("heat_stencil_5pt_stream_tb: errors");
        $finish;
    end

    // Receiver stall, redrawn every cycle at the falling edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall);
    end

    // Effective grid side: the register value clamped to the supported range.
    function automatic int unsigned side_len();
        int unsigned n;
        n = grid_reg;
        if (n < hss_pkg::MIN_GRID)
            n = hss_pkg::MIN_GRID;
        if (n > hss_pkg::MAX_GRID_DEF)
            n = hss_pkg::MAX_GRID_DEF;
        return n;
    endfunction

    // Advance the stencil by one accepted sample; returns the updated cell if
    // the sample completes the neighborhood of an interior cell.
    task automatic advance_stencil(input hss_pkg::in_word_t w, output bit made,
                                   output hss_pkg::out_word_t upd_word);
        int unsigned                         n, r, c;
        logic signed [hss_pkg::SAMPLE_W-1:0] top, mid;
        longint                              north, south, east, west, ctr, diff, prod, sum;
        n = side_len();
        r = pos_row;
        c = pos_col;
        made = 1'b0;
        upd_word = '0;
        // A frame start or a position beyond a shrunk grid restarts at the origin.
        if (w.frame_start || r >= n || c >= n)
        begin
            r = 0;
            c = 0;
        end
        top = older_line[c];
        mid = recent_line[c];
        older_line[c] = mid;
        recent_line[c] = w.sample;
        if (r >= 2 && c >= 2)
        begin
            north = win_top;
            west  = win_west;
            ctr   = win_mid;
            east  = mid;
            south = win_last;
            diff  = north + south + east + west - 4 * ctr;
            prod  = longint'(lambda_reg) * diff;
            // Arithmetic shift floors negative products.
            sum   = ctr + (prod >>> hss_pkg::Q_FRAC);
            if (sum > SAT_HI)
                sum = SAT_HI;
            if (sum < SAT_LO)
                sum = SAT_LO;
            upd_word.new_value = sum[hss_pkg::SAMPLE_W-1:0];
            upd_word.row_index = hss_pkg::IDX_W'(r - 1);
            upd_word.col_index = hss_pkg::IDX_W'(c - 1);
            upd_word.last      = (r == n - 1) && (c == n - 1);
            made = 1'b1;
        end
        win_top  = top;
        win_west = win_mid;
        win_mid  = mid;
        win_last = w.sample;
        c++;
        if (c >= n)
        begin
            c = 0;
            r++;
            if (r >= n)
                r = 0;
        end
        pos_row = r;
        pos_col = c;
    endtask

    // Offer one sample word, with random sender gaps, and record what it causes.
    task automatic send_sample(input hss_pkg::in_word_t w, input bit typed,
                               input hss_pkg::out_word_t typed_cell);
        bit                 made;
        hss_pkg::out_word_t upd_word;
        while ($urandom_range(99) < send_gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        advance_stencil(w, made, upd_word);
        if (typed)
            pending_cells.push_back(typed_cell);
        else if (made)
            pending_cells.push_back(upd_word);
        @(negedge clk);
    endtask

    // Write one register; returns at a falling edge with cfg_valid low.
    task automatic cfg_write(input logic [hss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hss_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            hss_pkg::CFG_GRID_SIZE:  grid_reg = data[hss_pkg::GRID_W-1:0];
            hss_pkg::CFG_LAMBDA_Q16: lambda_reg = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Both registers; the unused upper bits of the grid word are random.
    task automatic set_grid_lambda(input logic [hss_pkg::GRID_W-1:0] g,
                                   input logic [hss_pkg::LAMBDA_W-1:0] lam);
        cfg_write(hss_pkg::CFG_GRID_SIZE, {5'($urandom_range(31)), g});
        cfg_write(hss_pkg::CFG_LAMBDA_Q16, lam);
    endtask

    // Stop offering and wait until every expected word is out and the pipe is empty.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_cells.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Directed 3 by 3 grid: corners, north, the other three neighbors, center.
    // The typed value lands on the last sample, which completes cell (1, 1).
    task automatic plan_grid3(input bit set_cfg, input logic [hss_pkg::GRID_W-1:0] g,
                              input logic [hss_pkg::LAMBDA_W-1:0] lam,
                              input logic signed [hss_pkg::SAMPLE_W-1:0] corner, north,
                              input logic signed [hss_pkg::SAMPLE_W-1:0] side, ctr,
                              input logic signed [hss_pkg::SAMPLE_W-1:0] expv);
        plan_row_t row;
        for (int k = 0; k < 9; k++)
        begin
            row.set_cfg = set_cfg && (k == 0);
            row.grid = g;
            row.lam = lam;
            row.w.frame_start = (k == 0);
            if (k == 4)
                row.w.sample = ctr;
            else if (k == 1)
                row.w.sample = north;
            else if (k == 3 || k == 5 || k == 7)
                row.w.sample = side;
            else
                row.w.sample = corner;
            row.typed = (k == 8);
            row.typed_val = expv;
            plan.push_back(row);
        end
    endtask

    // Random frames at the current side length until the word budget is spent.
    // Mostly whole frames; some are cut short, miss their frame start or carry
    // a stray one, and a phase may begin in the middle of a grid.
    task automatic stream_phase(input int budget);
        int unsigned       n, total, cut;
        int                sent, style, base;
        bit                first;
        hss_pkg::in_word_t w;
        n = side_len();
        total = n * n;
        sent = 0;
        first = 1'b1;
        while (sent < budget)
        begin
            style = $urandom_range(3);
            cut = total;
            if ($urandom_range(9) == 0)
                cut = $urandom_range(total, 1);
            base = int'($urandom_range(33554431)) - 16777216;
            for (int unsigned k = 0; k < cut && sent < budget; k++)
            begin
                if (k == 0)
                    w.frame_start = !((first && $urandom_range(1)) || $urandom_range(11) == 0);
                else
                    w.frame_start = ($urandom_range(199) == 0);
                if (style == 1)
                    w.sample = base + int'($urandom_range(2047)) - 1024;
                else if (style == 2 || (style == 3 && $urandom_range(3) == 0))
                begin
                    case ($urandom_range(4))
                        0:       w.sample = Q_MAX;
                        1:       w.sample = Q_MIN;
                        2:       w.sample = '0;
                        3:       w.sample = '1;
                        default: w.sample = 32'sd1;
                    endcase
                end
                else
                    w.sample = $urandom;
                send_sample(w, 1'b0, '0);
                sent++;
            end
            first = 1'b0;
        end
    endtask

    // Compare every accepted output word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_cells.size() == 0)
            begin
                $display("%0t: unexpected word value=%h row=%0d col=%0d last=%b", $time,
                         out_data.new_value, out_data.row_index, out_data.col_index,
                         out_data.last);
                err_cnt++;
            end
            else
            begin
                want = pending_cells.pop_front();
                if (out_data.new_value !== want.new_value
                    || out_data.row_index !== want.row_index
                    || out_data.col_index !== want.col_index
                    || out_data.last !== want.last)
                begin
                    $display("%0t: expected value=%h row=%0d col=%0d last=%b,", $time,
                             want.new_value, want.row_index, want.col_index, want.last);
                    $display("%0t:   actual value=%h row=%0d col=%0d last=%b", $time,
                             out_data.new_value, out_data.row_index, out_data.col_index,
                             out_data.last);
                    err_cnt++;
                end
            end
        end
    end

    // Main sequence: reset, default-register pass, directed plan, random phases.
    initial
    begin
        logic [hss_pkg::GRID_W-1:0]   g;
        logic [hss_pkg::LAMBDA_W-1:0] lam;
        hss_pkg::out_word_t           typed_cell;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        grid_reg   = hss_pkg::GRID_SIZE_RST;
        lambda_reg = hss_pkg::LAMBDA_RST;
        foreach (older_line[i])
        begin
            older_line[i]  = '0;
            recent_line[i] = '0;
        end
        win_top  = '0;
        win_west = '0;
        win_mid  = '0;
        win_last = '0;
        pos_row  = 0;
        pos_col  = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Registers at their reset values: part of a full-width first row,
        // which completes no interior cell.
        stream_phase(hss_pkg::MAX_GRID_DEF / 2 + 12);

        // Directed: saturation both ways at full lambda, then a clamped grid side
        // with the smallest lambda, where the negative product floors to -1.
        plan_grid3(1'b1, 11'd3, 16'hFFFF, '0, Q_MAX, Q_MAX, Q_MIN, Q_MAX);
        plan_grid3(1'b0, 11'd3, 16'hFFFF, '1, Q_MIN, Q_MIN, Q_MAX, Q_MIN);
        plan_grid3(1'b1, 11'd2, 16'd1, Q_MAX, '1, '0, '0, '1);
        foreach (plan[i])
        begin
            if (plan[i].set_cfg)
            begin
                settle();
                set_grid_lambda(plan[i].grid, plan[i].lam);
            end
            typed_cell.new_value = plan[i].typed_val;
            typed_cell.row_index = hss_pkg::IDX_W'(1);
            typed_cell.col_index = hss_pkg::IDX_W'(1);
            typed_cell.last      = 1'b1;
            send_sample(plan[i].w, plan[i].typed, typed_cell);
        end

        // Oversized grid register clamps to the largest side; the spare index
        // must leave both registers alone.
        send_gap = 28;
        recv_stall = 28;
        settle();
        set_grid_lambda(11'h7FF, 16'($urandom));
        cfg_write(CFG_SPARE_IDX, 16'hFFFF);
        stream_phase(hss_pkg::MAX_GRID_DEF / 4);

        // Random phases under each idling pattern.
        for (int m = 0; m < 4; m++)
        begin
            case (m)
                0:       begin send_gap = 0;  recv_stall = 0;  end
                1:       begin send_gap = 63; recv_stall = 0;  end
                2:       begin send_gap = 0;  recv_stall = 63; end
                default: begin send_gap = 28; recv_stall = 28; end
            endcase
            for (int j = 0; j < 3; j++)
            begin
                settle();
                if (j == 0)
                begin
                    g = 11'd3;
                    lam = 16'hFFFF;
                end
                else if (j == 1)
                begin
                    g = 11'd1;
                    lam = 16'd0;
                end
                else
                begin
                    case ($urandom_range(9))
                        0:       g = 11'd0;
                        1:       g = 11'd2;
                        2:       g = 11'd4;
                        3:       g = 11'd5;
                        4:       g = 11'd6;
                        5:       g = 11'd7;
                        6:       g = 11'd9;
                        7:       g = 11'd12;
                        8:       g = 11'd16;
                        default: g = 11'($urandom_range(14, 3));
                    endcase
                    case ($urandom_range(4))
                        0:       lam = 16'd0;
                        1:       lam = 16'hFFFF;
                        2:       lam = 16'd16384;
                        3:       lam = 16'($urandom_range(255, 1));
                        default: lam = 16'($urandom);
                    endcase
                end
                set_grid_lambda(g, lam);
                stream_phase((side_len() * side_len() > 60) ? side_len() * side_len() : 60);
            end
        end

        settle();
        if (err_cnt == 0 && pending_cells.size() == 0)
            $display("heat_stencil_5pt_stream_tb: clean");
        else
            $display("heat_stencil_5pt_stream_tb: errors");
        $finish;
    end

endmodule
